// File: src/bed_pkg.sv
// ----------------------------------------------------------------------------
// bed_pkg
// Shared types and constants for the button event detector: register
// indexes, input mode codes, key class width and the packed result layout.
// ----------------------------------------------------------------------------
package bed_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_INPUT_MODE      = 3'd0,
    REG_DEBOUNCE_ENABLE = 3'd1,
    REG_DEBOUNCE_MS     = 3'd2,
    REG_DOUBLE_CLICK_MS = 3'd3,
    REG_HOLD_MS         = 3'd4,
    REG_KEY_COUNT       = 3'd5,
    REG_KEY_LIMITS      = 3'd6
  } reg_index_t;

  // Input mode codes (anything else selects the analog ladder)
  localparam logic [1:0] MODE_IDLE_HIGH = 2'd0;
  localparam logic [1:0] MODE_IDLE_LOW  = 2'd1;
  localparam logic [1:0] MODE_LADDER    = 2'd2;

  // Number of 16-bit limits packed into the key_limits register
  localparam int unsigned PACKED_LIMITS = 4;
  localparam int unsigned LIMIT_W       = 16;

  // Key class: key index, or the key count meaning "released"
  localparam int unsigned CLASS_W = 3;
  typedef logic [CLASS_W-1:0] key_class_t;

  // Millisecond time
  typedef logic [31:0] ms_t;

  // One result item, last field in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] press_count;
    logic        double_click_flag;
    logic        state_changed;
    logic        hold_event;
    logic        double_click_event;
    logic        release_event;
    logic        press_event;
    logic [1:0]  active_key;
    logic        is_pressed;
  } result_t;

endpackage

// File: src/button_event_detector_unit.sv
// ----------------------------------------------------------------------------
// button_event_detector_unit
// Debounced press / release / double-click / hold detection on polled pin
// samples, for one digital button or an analog ladder of keys.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one poll per request, tdata = {now_ms, pin_sample} with
//     pin_sample in the low SAMPLE_BITS bits, zero padded to whole bytes.
//   m_* channel: one result per poll, fields listed at the m_tdata port.
//   cfg_* channel: register writes (index, data), always ready; write only
//     while no poll is in flight.
// Path: an accepted poll passes the input register, then the result register,
//   before its result shows on m_tvalid.
// Throughput: one poll per cycle while m_tready is high. The debounce/press
//   state is read and updated by the single step between the input register
//   and the result register, so consecutive polls follow in consecutive cycles.
// Stall: while m_tready is low the result register holds and the input
//   register still takes one more poll; s_tready drops only when both are
//   full.
// Reset: rst (synchronous) empties both stages, loads the default register
//   values and returns the button to released, with the hold event disarmed
//   and all counters at zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
module button_event_detector_unit #(
  parameter int unsigned MAX_KEYS    = 4,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic             clk,
  input  logic             rst,
  // input polls
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [((SAMPLE_BITS+32+7)/8)*8-1:0] s_tdata, // pin_sample, now_ms, zero pad
  // results
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,  // is_pressed, active_key[1:0], press_event,
                                     // release_event, double_click_event, hold_event,
                                     // state_changed, double_click_flag,
                                     // press_count[15:0], zero pad
  // configuration writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_data
);

  localparam int unsigned KEY_LIM =
    (MAX_KEYS < bed_pkg::PACKED_LIMITS) ? MAX_KEYS : bed_pkg::PACKED_LIMITS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]  input_mode;
  logic        debounce_enable;
  logic [15:0] debounce_ms;
  logic [15:0] double_click_ms;
  logic [15:0] hold_ms;
  logic [2:0]  key_count;
  logic [63:0] key_limits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_mode      <= bed_pkg::MODE_IDLE_HIGH;
      debounce_enable <= 1'b1;
      debounce_ms     <= 16'd50;
      double_click_ms <= 16'd900;
      hold_ms         <= 16'd1000;
      key_count       <= 3'd1;
      key_limits      <= 64'd1024;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bed_pkg::reg_index_t'(cfg_index))
        bed_pkg::REG_INPUT_MODE:      input_mode      <= cfg_data[1:0];
        bed_pkg::REG_DEBOUNCE_ENABLE: debounce_enable <= cfg_data[0];
        bed_pkg::REG_DEBOUNCE_MS:     debounce_ms     <= cfg_data[15:0];
        bed_pkg::REG_DOUBLE_CLICK_MS: double_click_ms <= cfg_data[15:0];
        bed_pkg::REG_HOLD_MS:         hold_ms         <= cfg_data[15:0];
        bed_pkg::REG_KEY_COUNT:       key_count       <= cfg_data[2:0];
        bed_pkg::REG_KEY_LIMITS:      key_limits      <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: input register feeding result register
  // --------------------------------------------------------------------------
  logic                   in_valid;
  logic [SAMPLE_BITS-1:0] in_sample;
  bed_pkg::ms_t           in_now;
  logic                   out_valid;
  bed_pkg::result_t       result;
  logic                   out_free;
  logic                   step;

  assign out_free = !out_valid || m_tready;
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;
  assign m_tvalid = out_valid;
  assign m_tdata  = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata[SAMPLE_BITS-1:0];
      in_now    <= s_tdata[SAMPLE_BITS+31:SAMPLE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Button state
  // --------------------------------------------------------------------------
  bed_pkg::key_class_t last_class, last_class_next;
  bed_pkg::ms_t        debounce_start, debounce_start_next;
  logic                press_active, press_active_next;
  bed_pkg::ms_t        press_start, press_start_next;
  bed_pkg::ms_t        prev_press_start, prev_press_start_next;
  logic                hold_done, hold_done_next;
  logic                double_found, double_found_next;
  logic                changed_flag, changed_flag_next;
  logic [1:0]          latched_key, latched_key_next;
  logic [15:0]         presses, presses_next;

  // Effective key count
  logic [2:0] keys;
  always_comb begin
    priority if (input_mode == bed_pkg::MODE_IDLE_HIGH ||
                 input_mode == bed_pkg::MODE_IDLE_LOW) begin
      keys = 3'd1;
    end else if (key_count == 3'd0) begin
      keys = 3'd1;
    end else if (key_count > 3'(KEY_LIM)) begin
      keys = 3'(KEY_LIM);
    end else begin
      keys = key_count;
    end
  end

  // Sample classification: in ladder mode the lowest-index key whose limit lies above the sample wins
  bed_pkg::key_class_t cls;
  logic [15:0]         sample_ext;
  logic                idle_level;
  assign sample_ext = 16'(in_sample);
  assign idle_level = (input_mode == bed_pkg::MODE_IDLE_HIGH);

  always_comb begin
    cls = keys;
    if (input_mode == bed_pkg::MODE_IDLE_HIGH || input_mode == bed_pkg::MODE_IDLE_LOW) begin
      cls = (in_sample[0] == idle_level) ? bed_pkg::key_class_t'(1) :
                                           bed_pkg::key_class_t'(0);
    end else begin
      for (int i = bed_pkg::PACKED_LIMITS - 1; i >= 0; i--) begin
        if (3'(i) < keys &&
            sample_ext < key_limits[i*bed_pkg::LIMIT_W +: bed_pkg::LIMIT_W]) begin
          cls = bed_pkg::key_class_t'(i);
        end
      end
    end
  end

  // Elapsed times, modulo 2^32
  bed_pkg::ms_t since_debounce, since_prev_press, since_press;
  assign since_debounce   = in_now - debounce_start;
  assign since_prev_press = in_now - prev_press_start;
  assign since_press      = in_now - press_start;

  logic evaluate, key_down;
  logic ev_press, ev_rel, ev_dbl, ev_hold;
  assign evaluate = (cls == last_class) &&
                    !(debounce_enable && since_debounce < 32'(debounce_ms));
  assign key_down = (cls < keys);

  // Next state and events for the poll in the input register
  always_comb begin
    last_class_next       = cls;
    debounce_start_next   = debounce_start;
    press_active_next     = press_active;
    press_start_next      = press_start;
    prev_press_start_next = prev_press_start;
    hold_done_next        = hold_done;
    double_found_next     = double_found;
    changed_flag_next     = changed_flag;
    latched_key_next      = latched_key;
    presses_next          = presses;
    ev_press = 1'b0;
    ev_rel   = 1'b0;
    ev_dbl   = 1'b0;
    ev_hold  = 1'b0;
    if (cls != last_class) begin
      debounce_start_next = in_now;
    end else if (evaluate) begin
      if (key_down) begin
        if (!press_active) begin
          presses_next      = presses + 16'd1;
          latched_key_next  = cls[1:0];
          ev_press          = 1'b1;
          press_start_next  = in_now;
          press_active_next = 1'b1;
          hold_done_next    = 1'b0;
          changed_flag_next = 1'b1;
        end else begin
          changed_flag_next = 1'b0;
          // hold can only fire on a press already in progress
          if (!hold_done && since_press > 32'(hold_ms)) begin
            ev_hold        = 1'b1;
            hold_done_next = 1'b1;
          end
        end
      end else begin
        if (press_active) begin
          ev_rel                = 1'b1;
          ev_dbl                = (since_prev_press <= 32'(double_click_ms));
          double_found_next     = ev_dbl;
          prev_press_start_next = press_start;
          press_active_next     = 1'b0;
          changed_flag_next     = 1'b1;
        end else begin
          changed_flag_next = 1'b0;
        end
      end
    end
  end

  // State update, one poll per step
  always_ff @(posedge clk) begin
    if (rst) begin
      last_class       <= bed_pkg::key_class_t'(1);
      debounce_start   <= '0;
      press_active     <= 1'b0;
      press_start      <= '0;
      prev_press_start <= '0;
      hold_done        <= 1'b1;
      double_found     <= 1'b0;
      changed_flag     <= 1'b0;
      latched_key      <= 2'd0;
      presses          <= 16'd0;
    end else if (step) begin
      last_class       <= last_class_next;
      debounce_start   <= debounce_start_next;
      press_active     <= press_active_next;
      press_start      <= press_start_next;
      prev_press_start <= prev_press_start_next;
      hold_done        <= hold_done_next;
      double_found     <= double_found_next;
      changed_flag     <= changed_flag_next;
      latched_key      <= latched_key_next;
      presses          <= presses_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (step) begin
      result.pad                <= '0;
      result.press_count        <= presses_next;
      result.double_click_flag  <= double_found_next;
      result.state_changed      <= changed_flag_next;
      result.hold_event         <= ev_hold;
      result.double_click_event <= ev_dbl;
      result.release_event      <= ev_rel;
      result.press_event        <= ev_press;
      result.active_key         <= latched_key_next;
      result.is_pressed         <= press_active_next;
    end
  end

`ifndef ASSERT_OFF
  // A stalled poll in the input register is never dropped
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_free |=> in_valid)
    else $error("poll lost from input register");

  // A press event always bumps the press counter by one
  a_press_count: assert property (@(posedge clk) disable iff (rst)
    step && ev_press |=> presses == $past(presses) + 16'd1)
    else $error("press counter out of step with press event");

  // Double click only comes with a release, never with a press or hold
  a_dbl_release: assert property (@(posedge clk) disable iff (rst)
    step && ev_dbl |-> ev_rel && !ev_press && !ev_hold)
    else $error("double click without release");

  // Hold event only while the press stays active
  a_hold_active: assert property (@(posedge clk) disable iff (rst)
    step && ev_hold |=> press_active && hold_done)
    else $error("hold event outside an active press");
`endif

endmodule

// File: tb/sv/button_event_detector_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_event_detector_unit_tb
// Drives polls (pin sample + millisecond time) into the detector and checks
// every result against a cycle-free model of the debounce, press, release,
// double-click and hold logic kept inside the bench. Covers digital and
// ladder modes, time wrap, register extremes, random clicks with bounce and
// noise, idle gaps on both streams and a long result-side stall.
// ----------------------------------------------------------------------------
module button_event_detector_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_STALL  = 120;
  localparam int unsigned LADDER_MAX  = 4;   // min(MAX_KEYS, PACKED_LIMITS)
  localparam int unsigned CFG_EVERY   = 90;  // polls between random settings

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata   = '0;  // pin_sample[9:0], now_ms[31:0], zero pad
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;         // result_t layout from the package
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data  = '0;

  button_event_detector_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // Register copy
  logic [1:0]  mode_r;
  logic        deb_en_r;
  logic [15:0] deb_ms_r;
  logic [15:0] dbl_ms_r;
  logic [15:0] hold_ms_r;
  logic [2:0]  keys_r;
  logic [63:0] limits_r;

  // Button state
  bed_pkg::key_class_t prev_class;
  bed_pkg::ms_t        bounce_t0;
  logic                held;
  bed_pkg::ms_t        held_since;
  bed_pkg::ms_t        prior_since;
  logic                hold_fired;
  logic                dbl_seen;
  logic                change_seen;
  logic [1:0]          latch_key;
  logic [15:0]         press_total;

  bed_pkg::result_t expected_results[$];
  bed_pkg::ms_t     clock_ms = '0;

  int unsigned send_idle_pct = 0;
  int unsigned rcv_idle_pct  = 0;
  logic        stall_on      = 1'b0;
  event        long_stall_ev;

  int unsigned cycle_count   = 0;
  int unsigned polls_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned cfg_writes    = 0;
  int unsigned mismatches    = 0;
  int unsigned presses_seen  = 0;
  int unsigned releases_seen = 0;
  int unsigned doubles_seen  = 0;
  int unsigned holds_seen    = 0;

  // --------------------------------------------------------------------------
  // Detector model
  // --------------------------------------------------------------------------
  task automatic reset_detector_model();
    mode_r      = bed_pkg::MODE_IDLE_HIGH;
    deb_en_r    = 1'b1;
    deb_ms_r    = 16'd50;
    dbl_ms_r    = 16'd900;
    hold_ms_r   = 16'd1000;
    keys_r      = 3'd1;
    limits_r    = 64'd1024;
    prev_class  = bed_pkg::key_class_t'(1);
    bounce_t0   = '0;
    held        = 1'b0;
    held_since  = '0;
    prior_since = '0;
    hold_fired  = 1'b1;
    dbl_seen    = 1'b0;
    change_seen = 1'b0;
    latch_key   = '0;
    press_total = '0;
  endtask

  // keys in use; digital modes always have one
  function automatic int unsigned ladder_keys();
    int unsigned k;
    if (mode_r < bed_pkg::MODE_LADDER) return 1;
    k = (keys_r == 0) ? 1 : keys_r;
    return (k > LADDER_MAX) ? LADDER_MAX : k;
  endfunction

  // key index, or the key count for released
  function automatic bed_pkg::key_class_t class_of(logic [9:0] s, int unsigned keys);
    if (mode_r < bed_pkg::MODE_LADDER)
      return (s[0] == (mode_r == bed_pkg::MODE_IDLE_HIGH)) ?
             bed_pkg::key_class_t'(1) : bed_pkg::key_class_t'(0);
    for (int i = 0; i < keys; i++)
      if (s < limits_r[16*i +: 16]) return bed_pkg::key_class_t'(i);
    return bed_pkg::key_class_t'(keys);
  endfunction

  function automatic bed_pkg::result_t predict_poll(logic [9:0] s, bed_pkg::ms_t now);
    int unsigned         keys;
    bed_pkg::key_class_t cls;
    bed_pkg::result_t    r;
    bed_pkg::ms_t        elapsed;
    keys = ladder_keys();
    cls  = class_of(s, keys);
    r    = '0;
    if (cls != prev_class) begin
      bounce_t0 = now;
    end else begin
      elapsed = now - bounce_t0;
      if (!(deb_en_r && elapsed < deb_ms_r)) begin
        if (cls < keys) begin
          if (!held) begin
            press_total   = press_total + 16'd1;
            latch_key     = cls[1:0];
            r.press_event = 1'b1;
            held_since    = now;
            held          = 1'b1;
            hold_fired    = 1'b0;
            change_seen   = 1'b1;
          end else begin
            change_seen = 1'b0;
          end
        end else begin
          if (held) begin
            r.release_event = 1'b1;
            elapsed = now - prior_since;
            dbl_seen = (elapsed <= dbl_ms_r);
            r.double_click_event = dbl_seen;
            prior_since = held_since;
            held        = 1'b0;
            change_seen = 1'b1;
          end else begin
            change_seen = 1'b0;
          end
        end
        // one hold per press
        elapsed = now - held_since;
        if (held && !hold_fired && elapsed > hold_ms_r) begin
          r.hold_event = 1'b1;
          hold_fired   = 1'b1;
        end
      end
    end
    prev_class          = cls;
    r.is_pressed        = held;
    r.active_key        = latch_key;
    r.state_changed     = change_seen;
    r.double_click_flag = dbl_seen;
    r.press_count       = press_total;
    return r;
  endfunction

  // sample landing in a given class under the current settings
  function automatic logic [9:0] sample_for(int unsigned cls);
    int unsigned keys, lo, hi;
    logic [9:0]  s;
    keys = ladder_keys();
    s = 10'($urandom);
    if (mode_r < bed_pkg::MODE_LADDER) begin
      s[0] = (cls == 0) ^ (mode_r == bed_pkg::MODE_IDLE_HIGH);
      return s;
    end
    lo = (cls == 0) ? 0 : limits_r[16*(cls-1) +: 16];
    hi = (cls < keys) ? limits_r[16*cls +: 16] : 1024;
    if (hi > 1024) hi = 1024;
    if (lo < hi) s = 10'($urandom_range(hi - 1, lo));
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Stream drivers
  // --------------------------------------------------------------------------
  task automatic send_poll(logic [9:0] s, bed_pkg::ms_t now);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, now, s};
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_poll(s, now));
    polls_sent++;
  endtask

  task automatic poll_after(logic [9:0] s, int unsigned dt);
    clock_ms = clock_ms + dt;
    send_poll(s, clock_ms);
  endtask

  // stop offering polls and let every pending result come out
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(bed_pkg::reg_index_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    case (idx)
      bed_pkg::REG_INPUT_MODE:      mode_r    = val[1:0];
      bed_pkg::REG_DEBOUNCE_ENABLE: deb_en_r  = val[0];
      bed_pkg::REG_DEBOUNCE_MS:     deb_ms_r  = val[15:0];
      bed_pkg::REG_DOUBLE_CLICK_MS: dbl_ms_r  = val[15:0];
      bed_pkg::REG_HOLD_MS:         hold_ms_r = val[15:0];
      bed_pkg::REG_KEY_COUNT:       keys_r    = val[2:0];
      bed_pkg::REG_KEY_LIMITS:      limits_r  = val;
      default: ;
    endcase
  endtask

  task automatic load_config(logic [1:0] mode, logic deb_en, logic [15:0] deb_ms,
                             logic [15:0] dbl_ms, logic [15:0] hold, logic [2:0] kc,
                             logic [63:0] limits);
    write_reg(bed_pkg::REG_INPUT_MODE, 64'(mode));
    write_reg(bed_pkg::REG_DEBOUNCE_ENABLE, 64'(deb_en));
    write_reg(bed_pkg::REG_DEBOUNCE_MS, 64'(deb_ms));
    write_reg(bed_pkg::REG_DOUBLE_CLICK_MS, 64'(dbl_ms));
    write_reg(bed_pkg::REG_HOLD_MS, 64'(hold));
    write_reg(bed_pkg::REG_KEY_COUNT, 64'(kc));
    write_reg(bed_pkg::REG_KEY_LIMITS, limits);
    cfg_valid <= 1'b0;
  endtask

  // mostly mid-range times, now and then zero or full scale
  function automatic logic [15:0] pick_ms(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(19, 0);
    if (r < 2) return 16'd0;
    if (r == 2) return 16'hFFFF;
    return 16'($urandom_range(hi, lo));
  endfunction

  task automatic random_config();
    logic [63:0]  limits;
    int unsigned  r, a, b, c, d;
    r = $urandom_range(19, 0);
    if (r < 2) begin
      limits = '1;
    end else if (r == 2) begin
      limits = '0;
    end else begin
      a = $urandom_range(200, 1);
      b = a + $urandom_range(250, 1);
      c = b + $urandom_range(250, 1);
      d = c + $urandom_range(300, 1);
      limits = {16'(d), 16'(c), 16'(b), 16'(a)};
    end
    load_config(2'($urandom_range(3, 0)), ($urandom_range(3, 0) != 0),
                pick_ms(1, 150), pick_ms(50, 1500), pick_ms(20, 1500),
                3'($urandom_range(7, 0)), limits);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus sequences
  // --------------------------------------------------------------------------
  // bounce in, press, maybe hold, bounce out, release, maybe long pause
  task automatic click_sequence();
    int unsigned keys, key, base;
    keys = ladder_keys();
    key  = $urandom_range(keys - 1, 0);
    base = (deb_en_r && deb_ms_r != 0) ? deb_ms_r : 20;
    repeat ($urandom_range(2, 0))
      poll_after(sample_for($urandom_range(keys, 0)), $urandom_range((base + 1) / 2, 1));
    poll_after(sample_for(key), $urandom_range((base + 1) / 2, 1));
    repeat ($urandom_range(4, 1))
      poll_after(sample_for(key), $urandom_range(base, (base + 1) / 2));
    if ($urandom_range(9, 0) < 4)
      poll_after(sample_for(key), hold_ms_r + $urandom_range(3, 0));
    repeat ($urandom_range(2, 0))
      poll_after(sample_for($urandom_range(keys, 0)), $urandom_range((base + 1) / 2, 1));
    poll_after(sample_for(keys), $urandom_range((base + 1) / 2, 1));
    repeat ($urandom_range(3, 1))
      poll_after(sample_for(keys), $urandom_range(base, (base + 1) / 2));
    if ($urandom_range(3, 0) == 0)
      poll_after(sample_for(keys), $urandom_range(2 * dbl_ms_r + 10, 0));
  endtask

  // arbitrary samples and time steps, sometimes a jump anywhere in time
  task automatic noise_burst();
    repeat ($urandom_range(4, 1)) begin
      if ($urandom_range(9, 0) == 0) clock_ms = $urandom;
      poll_after(10'($urandom), $urandom_range(300, 0));
    end
  endtask

  task automatic run_random(int unsigned count);
    int unsigned stop_at, next_cfg;
    stop_at  = polls_sent + count;
    next_cfg = polls_sent + CFG_EVERY;
    while (polls_sent < stop_at) begin
      if (polls_sent >= next_cfg) begin
        wait_idle();
        random_config();
        next_cfg = polls_sent + CFG_EVERY;
      end
      if ($urandom_range(99, 0) < 80) click_sequence();
      else noise_burst();
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // reset settings: debounce, first release against time zero, hold, bit 0 only
  task automatic test_digital_defaults();
    clock_ms = '0;
    poll_after(10'h3FF, 0);     // released, still inside debounce
    poll_after(10'h000, 10);    // class change
    poll_after(10'h3FE, 60);    // press
    poll_after(10'h001, 230);   // class change
    poll_after(10'h3FF, 60);    // release, first one: double click vs zero
    poll_after(10'h000, 40);
    poll_after(10'h000, 60);    // press
    poll_after(10'h000, 1040);  // hold
    poll_after(10'h001, 10);
    poll_after(10'h001, 60);    // release, outside double click window
  endtask

  // idle-low level, no debounce, zero windows, time wrapping past 2^32
  task automatic test_idle_low_wrap();
    wait_idle();
    load_config(bed_pkg::MODE_IDLE_LOW, 1'b0, 16'hFFFF, 16'd0, 16'd0, 3'd7, 64'd0);
    clock_ms = 32'hFFFF_FFFC;
    poll_after(10'h000, 1);
    poll_after(10'h001, 1);
    poll_after(10'h3FF, 1);     // press right before the wrap
    poll_after(10'h3FF, 3);     // hold across the wrap
    poll_after(10'h000, 1);
    poll_after(10'h3FE, 1);     // release
  endtask

  // mode three acts as the ladder; key count above four saturates
  task automatic test_ladder_keys();
    wait_idle();
    load_config(2'd3, 1'b1, 16'd0, 16'hFFFF, 16'hFFFF, 3'd7,
                {16'd900, 16'd600, 16'd300, 16'd100});
    poll_after(10'd0, 5);
    poll_after(10'd0, 5);       // key 0 press
    poll_after(10'd1023, 5);
    poll_after(10'd1023, 5);    // release
    poll_after(10'd150, 5);
    poll_after(10'd150, 5);     // key 1 press
    poll_after(10'd650, 5);     // other key while pressed
    poll_after(10'd650, 5);
    poll_after(10'd1023, 5);
    poll_after(10'd1023, 5);
  endtask

  // result side held off while polls keep coming, input must stall
  task automatic test_result_backpressure();
    wait_idle();
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    load_config(bed_pkg::MODE_LADDER, 1'b1, 16'd20, 16'd900, 16'd100, 3'd4,
                {16'd1000, 16'd700, 16'd400, 16'd200});
    -> long_stall_ev;
    repeat (3) click_sequence();
  endtask

  task automatic test_random_sender_idle();
    wait_idle();
    send_idle_pct = 26;
    rcv_idle_pct  = 57;
    random_config();
    run_random(290);
  endtask

  task automatic test_random_receiver_idle();
    wait_idle();
    send_idle_pct = 57;
    rcv_idle_pct  = 26;
    random_config();
    run_random(290);
  endtask

  task automatic test_random_streaming();
    wait_idle();
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    random_config();
    run_random(290);
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready pattern, long hold-off, checking
  // --------------------------------------------------------------------------
  always @(posedge clk)
    m_tready <= !stall_on && ($urandom_range(99, 0) >= rcv_idle_pct);

  initial forever begin
    @(long_stall_ev);
    stall_on <= 1'b1;
    repeat (LONG_STALL) @(posedge clk);
    stall_on <= 1'b0;
  end

  function automatic void check_field(string name, logic [15:0] expv, logic [15:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    bed_pkg::result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = bed_pkg::result_t'(m_tdata);
      if (expected_results.size() == 0) begin
        $error("result %h with no poll pending", m_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("is_pressed", want.is_pressed, got.is_pressed);
        check_field("active_key", want.active_key, got.active_key);
        check_field("press_event", want.press_event, got.press_event);
        check_field("release_event", want.release_event, got.release_event);
        check_field("double_click_event", want.double_click_event, got.double_click_event);
        check_field("hold_event", want.hold_event, got.hold_event);
        check_field("state_changed", want.state_changed, got.state_changed);
        check_field("double_click_flag", want.double_click_flag, got.double_click_flag);
        check_field("press_count", want.press_count, got.press_count);
        results_seen++;
        presses_seen  += want.press_event;
        releases_seen += want.release_event;
        doubles_seen  += want.double_click_event;
        holds_seen    += want.hold_event;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, expected_results.size());
      $display("button_event_detector_unit_tb: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of tests
  // --------------------------------------------------------------------------
  initial begin
    reset_detector_model();
    send_idle_pct = 26;
    rcv_idle_pct  = 57;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_digital_defaults();
    test_idle_low_wrap();
    test_ladder_keys();
    test_result_backpressure();
    test_random_sender_idle();
    test_random_receiver_idle();
    test_random_streaming();

    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d polls, %0d results checked, %0d register writes, %0d cycles",
             polls_sent, results_seen, cfg_writes, cycle_count);
    $display("events: %0d presses, %0d releases, %0d double clicks, %0d holds",
             presses_seen, releases_seen, doubles_seen, holds_seen);
    if (mismatches == 0)
      $display("button_event_detector_unit_tb: done, clean");
    else
      $display("button_event_detector_unit_tb: done, errors");
    $finish;
  end

endmodule
